### sv/ascii_pump_telegram_builder_top_macros.svh
// Assertion macros for the pump telegram builder.
// Used by the top level; expects signals named clk and rst in the including scope.
`ifndef ASCII_PUMP_TELEGRAM_BUILDER_TOP_MACROS_SVH
`define ASCII_PUMP_TELEGRAM_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define APTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define APTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define APTB_ASSERT(lbl, prop, msg)
`define APTB_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### sv/aptb_pkg.sv
// Shared types, character codes and digit helpers for the pump telegram builder.
// No dependencies; the design and testbench modules use it by scoped names.
package aptb_pkg;

  typedef struct packed {
    logic [9:0]  device_address;
    logic [9:0]  parameter_number;
    logic [19:0] data_value;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } chr_t;

  // Telegram kinds.
  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  // One classified request with all decimal digits ready, lowest digit first.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] addr_dig;
    logic [11:0] param_dig;
    logic [23:0] data_dig;
  } desc_t;

  // Conversion takes two bits a cycle over a 20-bit source.
  localparam int unsigned SRC_BITS = 20;
  localparam logic [3:0]  CNT_LAST = 4'(SRC_BITS / 2 - 1);

  localparam logic [19:0] CLAMP_SHORT = 20'd999;
  localparam logic [19:0] CLAMP_LONG  = 20'd999999;

  localparam logic [4:0] LEN_QUERY = 5'd12;
  localparam logic [4:0] LEN_SHORT = 5'd13;
  localparam logic [4:0] LEN_LONG  = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;

  function automatic logic is_short_write(input logic [9:0] p);
    logic special;
    logic in_band;
    special = (p == 10'd708) || (p == 10'd720) || (p == 10'd797);
    in_band = (p >= 10'd17) && (p <= 10'd100) && (p != 10'd23) && (p != 10'd50) &&
              (p != 10'd61);
    return special || in_band;
  endfunction

  // One shift-and-add-3 step of binary to BCD conversion on six digits.
  function automatic logic [23:0] bcd_step(input logic [23:0] bcd, input logic b);
    logic [23:0] adj;
    adj = bcd;
    for (int i = 0; i < 6; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[22:0], b};
  endfunction

  // Splits a byte into three decimal digits, hundreds in the top nibble.
  function automatic logic [11:0] sum_to_bcd(input logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [3:0]  u;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 2'd0;
      r = v[6:0];
    end
    prod = 15'(r) * 15'd205;
    t    = 4'(prod >> 11);
    u    = 4'(r - {t, 3'b000} - {2'b00, t, 1'b0});
    return {2'b00, h, t, u};
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return {4'h3, d};
  endfunction

endpackage

### sv/ascii_pump_telegram_builder_top.sv
// Top level of the pump telegram builder: front end, request queue, serializer.
// Depends on aptb_pkg, aptb_front, aptb_queue, aptb_back and the macros header.
`include "ascii_pump_telegram_builder_top_macros.svh"

// A request carries a device address, a parameter number and a data value;
// the block answers with the ASCII telegram for it, one character per output
// transfer, with last_byte set on the closing carriage return. Parameters 300
// to 399 give a 16-character query; other parameters give a write of 17
// characters (three data digits, data clamped to 999) or 20 characters (six
// data digits, data clamped to 999999). Addresses and parameters above 999
// are sent as their low three decimal digits. For each request the front end
// first accepts and classifies it, in the same cycle handing the previous
// result to the queue, and then converts address, parameter and data to
// decimal two bits at a time. A two-entry queue then feeds the serializer,
// which emits one character per cycle while the output is not stalled. The
// serializer, not the front end, sets the sustained rate. An accepted request
// passes through conversion, the queue and the serializer's registered output
// stage before its first character leaves. The block holds no state across
// requests other than the queued ones.
module ascii_pump_telegram_builder_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  aptb_pkg::req_t  req,
  output logic            chr_valid,
  input  logic            chr_stall,
  output aptb_pkg::chr_t  chr
);

  logic            push;
  aptb_pkg::desc_t push_desc;
  logic            pop;
  aptb_pkg::desc_t head;
  logic            q_full;
  logic            q_empty;
  logic            push_digits_ok;

  // Classification and decimal conversion.
  aptb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .full      (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  // Decouples conversion from serialization so either side may stall alone.
  aptb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Character generation, checksum and the registered output stage.
  aptb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

  // Top digit of each field, the first to go wrong, and the lowest data digit.
  assign push_digits_ok = (push_desc.data_dig[23:20] <= 4'd9) &&
                          (push_desc.data_dig[3:0] <= 4'd9) &&
                          (push_desc.addr_dig[11:8] <= 4'd9) &&
                          (push_desc.param_dig[11:8] <= 4'd9);

  // The front end must never hand over a request the queue cannot hold.
  `APTB_ASSERT(a_no_push_when_full, !(push && q_full), "push into a full queue")
  // The top digit of each field and the lowest data digit must be valid decimal digits.
  `APTB_ASSERT_IMP(a_push_digits_bcd, push, push_digits_ok, "non-decimal digit pushed")
  // The serializer only pops when the queue has an entry.
  `APTB_ASSERT(a_no_pop_when_empty, !(pop && q_empty), "pop from an empty queue")

endmodule

### sv/aptb_front.sv
// Front end: accepts a request, classifies it, clamps the data and converts
// all fields to decimal digits. Depends on aptb_pkg.
module aptb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  aptb_pkg::req_t      req,
  input  logic                full,
  output logic                push,
  output aptb_pkg::desc_t     push_desc
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  logic [3:0]  cnt;
  logic [1:0]  kind;
  logic [19:0] asrc;
  logic [19:0] psrc;
  logic [19:0] dsrc;
  logic [23:0] abcd;
  logic [23:0] pbcd;
  logic [23:0] dbcd;

  logic        accept;
  logic        is_query;
  logic        is_short;
  logic [1:0]  kind_next;
  logic [19:0] data_clamped;

  assign req_stall = !((state == ST_IDLE) || ((state == ST_DONE) && !full));
  assign accept    = req_valid && !req_stall;
  assign push      = (state == ST_DONE) && !full;

  always_comb begin
    is_query = (req.parameter_number >= 10'd300) && (req.parameter_number <= 10'd399);
    is_short = aptb_pkg::is_short_write(req.parameter_number);
    if (is_query) begin
      kind_next    = aptb_pkg::KIND_QUERY;
      data_clamped = '0;
    end else if (is_short) begin
      kind_next    = aptb_pkg::KIND_SHORT;
      data_clamped = (req.data_value > aptb_pkg::CLAMP_SHORT) ? aptb_pkg::CLAMP_SHORT
                                                                : req.data_value;
    end else begin
      kind_next    = aptb_pkg::KIND_LONG;
      data_clamped = (req.data_value > aptb_pkg::CLAMP_LONG) ? aptb_pkg::CLAMP_LONG
                                                               : req.data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      priority if (accept) begin
        state <= ST_CONV;
        cnt   <= '0;
      end else if (state == ST_CONV) begin
        cnt <= cnt + 4'd1;
        if (cnt == aptb_pkg::CNT_LAST) begin
          state <= ST_DONE;
        end
      end else if (push) begin
        state <= ST_IDLE;
      end else begin
        state <= state;
      end
    end
  end

  // Two conversion steps per cycle, most significant source bits first.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= kind_next;
      asrc <= {10'd0, req.device_address};
      psrc <= {10'd0, req.parameter_number};
      dsrc <= data_clamped;
      abcd <= '0;
      pbcd <= '0;
      dbcd <= '0;
    end else if (state == ST_CONV) begin
      abcd <= aptb_pkg::bcd_step(aptb_pkg::bcd_step(abcd, asrc[19]), asrc[18]);
      pbcd <= aptb_pkg::bcd_step(aptb_pkg::bcd_step(pbcd, psrc[19]), psrc[18]);
      dbcd <= aptb_pkg::bcd_step(aptb_pkg::bcd_step(dbcd, dsrc[19]), dsrc[18]);
      asrc <= {asrc[17:0], 2'b00};
      psrc <= {psrc[17:0], 2'b00};
      dsrc <= {dsrc[17:0], 2'b00};
    end
  end

  // Values above 999 keep only their low three digits.
  assign push_desc.kind      = kind;
  assign push_desc.addr_dig  = abcd[11:0];
  assign push_desc.param_dig = pbcd[11:0];
  assign push_desc.data_dig  = dbcd;

endmodule

### sv/aptb_queue.sv
// Two-entry queue of converted requests between front end and serializer.
// Depends on aptb_pkg.
module aptb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  aptb_pkg::desc_t push_desc,
  input  logic            pop,
  output aptb_pkg::desc_t head,
  output logic            full,
  output logic            empty
);

  aptb_pkg::desc_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

endmodule

### sv/aptb_back.sv
// Serializer: turns one queued request into telegram bytes, one per cycle
// unless stalled, summing the checksum as it goes. Depends on aptb_pkg.
module aptb_back (
  input  logic            clk,
  input  logic            rst,
  input  aptb_pkg::desc_t head,
  input  logic            empty,
  output logic            pop,
  output logic            chr_valid,
  input  logic            chr_stall,
  output aptb_pkg::chr_t  chr
);

  logic            busy;
  logic [4:0]      idx;
  logic [7:0]      sum;
  aptb_pkg::desc_t cur;
  logic            ovalid;
  aptb_pkg::chr_t  odata;

  logic            advance;
  logic [4:0]      body_len;
  logic [4:0]      rel;
  logic [4:0]      didx_s;
  logic [4:0]      didx_l;
  logic [2:0]      didx;
  logic [3:0]      data_digit;
  logic [11:0]     cks;
  logic [7:0]      body_char;
  logic [7:0]      ch;
  logic            ch_last;
  logic            is_query;

  assign advance   = busy && (!ovalid || !chr_stall);
  assign pop       = (!busy || (advance && ch_last)) && !empty;
  assign chr_valid = ovalid;
  assign chr       = odata;

  always_comb begin
    is_query = (cur.kind == aptb_pkg::KIND_QUERY);
    unique case (cur.kind)
      aptb_pkg::KIND_QUERY: body_len = aptb_pkg::LEN_QUERY;
      aptb_pkg::KIND_SHORT: body_len = aptb_pkg::LEN_SHORT;
      default:              body_len = aptb_pkg::LEN_LONG;
    endcase
    rel    = idx - body_len;
    didx_s = 5'd12 - idx;
    didx_l = 5'd15 - idx;
    didx   = (cur.kind == aptb_pkg::KIND_SHORT) ? didx_s[2:0] : didx_l[2:0];
    unique case (didx)
      3'd0:    data_digit = cur.data_dig[3:0];
      3'd1:    data_digit = cur.data_dig[7:4];
      3'd2:    data_digit = cur.data_dig[11:8];
      3'd3:    data_digit = cur.data_dig[15:12];
      3'd4:    data_digit = cur.data_dig[19:16];
      3'd5:    data_digit = cur.data_dig[23:20];
      default: data_digit = 4'd0;
    endcase
    cks = aptb_pkg::sum_to_bcd(sum);

    unique case (idx)
      5'd0:  body_char = aptb_pkg::digit_char(cur.addr_dig[11:8]);
      5'd1:  body_char = aptb_pkg::digit_char(cur.addr_dig[7:4]);
      5'd2:  body_char = aptb_pkg::digit_char(cur.addr_dig[3:0]);
      5'd3:  body_char = is_query ? aptb_pkg::CH_ZERO : aptb_pkg::CH_ONE;
      5'd4:  body_char = aptb_pkg::CH_ZERO;
      5'd5:  body_char = aptb_pkg::digit_char(cur.param_dig[11:8]);
      5'd6:  body_char = aptb_pkg::digit_char(cur.param_dig[7:4]);
      5'd7:  body_char = aptb_pkg::digit_char(cur.param_dig[3:0]);
      5'd8:  body_char = aptb_pkg::CH_ZERO;
      5'd9: begin
        unique case (cur.kind)
          aptb_pkg::KIND_QUERY: body_char = aptb_pkg::CH_TWO;
          aptb_pkg::KIND_SHORT: body_char = aptb_pkg::CH_THREE;
          default:              body_char = aptb_pkg::CH_SIX;
        endcase
      end
      5'd10: body_char = is_query ? aptb_pkg::CH_EQUAL : aptb_pkg::digit_char(data_digit);
      5'd11: body_char = is_query ? aptb_pkg::CH_QUERY : aptb_pkg::digit_char(data_digit);
      default: body_char = aptb_pkg::digit_char(data_digit);
    endcase

    ch_last = 1'b0;
    if (idx < body_len) begin
      ch = body_char;
    end else begin
      unique case (rel)
        5'd0:    ch = aptb_pkg::digit_char(cks[11:8]);
        5'd1:    ch = aptb_pkg::digit_char(cks[7:4]);
        5'd2:    ch = aptb_pkg::digit_char(cks[3:0]);
        default: begin
          ch      = aptb_pkg::CH_CR;
          ch_last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (advance) begin
        ovalid <= 1'b1;
      end else if (!chr_stall) begin
        ovalid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && ch_last) begin
        busy <= 1'b0;
      end
    end
  end

  // The running sum wraps at eight bits, which is the checksum modulo 256.
  // Only body characters are summed, so the sum holds still while its own
  // three digits go out.
  always_ff @(posedge clk) begin
    if (advance) begin
      odata.out_byte  <= ch;
      odata.last_byte <= ch_last;
    end
    if (pop) begin
      cur <= head;
      idx <= '0;
      sum <= '0;
    end else if (advance) begin
      idx <= idx + 5'd1;
      if (idx < body_len) begin
        sum <= sum + ch;
      end
    end
  end

endmodule

### sim/telegram_checker.sv
// Checker for the pump telegram builder: predicts each telegram from the accepted
// request and compares every character leaving the block against it.
// Depends on aptb_pkg for the request and character types and character codes.
module telegram_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  aptb_pkg::req_t  req,
  input  logic            chr_valid,
  input  logic            chr_stall,
  input  aptb_pkg::chr_t  chr,
  output int              error_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUERY_LO = 300;
  localparam int unsigned QUERY_HI = 399;

  aptb_pkg::chr_t telegram_chars [$];
  logic [7:0]     draft [$];

  // Appends the low decimal digits of a value, most significant first.
  function automatic void append_digits(input int unsigned v, input int count);
    int unsigned rest;
    logic [7:0]  digs [6];
    rest = v;
    for (int i = 0; i < count; i++) begin
      digs[i] = aptb_pkg::CH_ZERO + 8'(rest % 10);
      rest    = rest / 10;
    end
    for (int i = count - 1; i >= 0; i--) begin
      draft.push_back(digs[i]);
    end
  endfunction

  function automatic bit three_digit_write(input int unsigned p);
    if (p == 708 || p == 720 || p == 797) begin
      return 1'b1;
    end
    return p >= 17 && p <= 100 && p != 23 && p != 50 && p != 61;
  endfunction

  function automatic void predict_telegram(input aptb_pkg::req_t r);
    int unsigned addr;
    int unsigned param;
    int unsigned value;
    int unsigned sum;
    addr  = r.device_address;
    param = r.parameter_number;
    value = r.data_value;
    sum   = 0;
    draft.delete();
    append_digits(addr, 3);
    if (param >= QUERY_LO && param <= QUERY_HI) begin
      draft.push_back(aptb_pkg::CH_ZERO);
      draft.push_back(aptb_pkg::CH_ZERO);
      append_digits(param, 3);
      draft.push_back(aptb_pkg::CH_ZERO);
      draft.push_back(aptb_pkg::CH_TWO);
      draft.push_back(aptb_pkg::CH_EQUAL);
      draft.push_back(aptb_pkg::CH_QUERY);
    end else begin
      draft.push_back(aptb_pkg::CH_ONE);
      draft.push_back(aptb_pkg::CH_ZERO);
      append_digits(param, 3);
      draft.push_back(aptb_pkg::CH_ZERO);
      if (three_digit_write(param)) begin
        draft.push_back(aptb_pkg::CH_THREE);
        append_digits((value > 999) ? 999 : value, 3);
      end else begin
        draft.push_back(aptb_pkg::CH_SIX);
        append_digits((value > 999999) ? 999999 : value, 6);
      end
    end
    foreach (draft[i]) begin
      sum += draft[i];
    end
    append_digits(sum % 256, 3);
    draft.push_back(aptb_pkg::CH_CR);
    foreach (draft[i]) begin
      telegram_chars.push_back('{out_byte: draft[i], last_byte: (i == draft.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    aptb_pkg::chr_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_telegram(req);
      end
      if (chr_valid && !chr_stall) begin
        if (telegram_chars.size() == 0) begin
          $error("unexpected character %h with no telegram pending", chr.out_byte);
          error_count++;
        end else begin
          want = telegram_chars.pop_front();
          if (chr.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, chr.out_byte);
            error_count++;
          end
          if (chr.last_byte !== want.last_byte) begin
            $error("last_byte: expected %b, got %b", want.last_byte, chr.last_byte);
            error_count++;
          end
        end
      end
      pending = telegram_chars.size();
    end
  end

endmodule

### sim/tb_top.sv
// Top of the pump telegram builder testbench: clock, reset, request stimulus,
// output stalls and the verdict. Depends on aptb_pkg, the block and telegram_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Number of random requests after the directed ones.
  localparam int RANDOM_REQUESTS = 246;
  // The receiver holds off this long once, well after the directed part, so the
  // front end and the two-entry queue fill up and the block stalls its input.
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 1500;
  // A telegram is at most 20 characters long.
  localparam int TAIL_CYCLES     = 60;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  aptb_pkg::req_t req;
  logic           chr_valid;
  logic           chr_stall;
  aptb_pkg::chr_t chr;

  int   error_count;
  int   pending;
  logic req_taken = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ascii_pump_telegram_builder_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

  telegram_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .chr_valid   (chr_valid),
    .chr_stall   (chr_stall),
    .chr         (chr),
    .error_count (error_count),
    .pending     (pending)
  );

  // The handshake is sampled at the rising edge, exactly as the block sees it.
  // The driving processes act at the falling edge and read this flag to learn
  // whether the request they hold was taken at the edge just passed.
  always @(posedge clk) begin
    req_taken <= req_valid && !req_stall;
  end

  // Holds one request on the input until the block takes it. The payload does
  // not change while the block stalls, and valid stays high on return so a
  // following request can go out back to back without a dip.
  task automatic offer(input aptb_pkg::req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  function automatic aptb_pkg::req_t pack_req(input int a, input int p, input int d);
    return '{device_address: 10'(a), parameter_number: 10'(p), data_value: 20'(d)};
  endfunction

  // Random requests lean on the query range and the three-digit write band,
  // where the format decisions sit, and on data near both clamp limits. The
  // address and the other picks cover the full field width so every bit toggles.
  function automatic aptb_pkg::req_t random_request();
    logic [9:0]  p;
    logic [19:0] d;
    case ($urandom_range(0, 7))
      0, 1: begin
        p = 10'($urandom_range(300, 399));
      end
      2, 3: begin
        p = 10'($urandom_range(17, 100));
      end
      4: begin
        case ($urandom_range(0, 5))
          0: p = 10'd23;
          1: p = 10'd50;
          2: p = 10'd61;
          3: p = 10'd708;
          4: p = 10'd720;
          default: p = 10'd797;
        endcase
      end
      default: begin
        p = 10'($urandom_range(0, 1023));
      end
    endcase
    case ($urandom_range(0, 5))
      0: d = 20'($urandom_range(0, 999));
      1: d = 20'($urandom_range(990, 1010));
      2: d = 20'($urandom_range(0, 999999));
      3: d = 20'($urandom_range(999990, 1048575));
      default: d = 20'($urandom());
    endcase
    return '{device_address: 10'($urandom_range(0, 1023)), parameter_number: p,
             data_value: d};
  endfunction

  // Receiver: stalls the character output in segments of random length, each
  // with its own pattern (never, coin flip, mostly stalled, or a regular
  // periodic stall), so stalls land on every character position of a telegram.
  // Once, at the point set by HOLD_AFTER, it stalls unbroken for LONG_HOLD.
  initial begin
    int mode;
    int seg_len;
    int cycle_count;
    bit held;
    chr_stall   = 1'b0;
    cycle_count = 0;
    held        = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 80);
      repeat (seg_len) begin
        @(negedge clk);
        cycle_count++;
        if (!held && cycle_count >= HOLD_AFTER) begin
          chr_stall <= 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
          cycle_count += LONG_HOLD;
          held = 1'b1;
        end
        case (mode)
          0: chr_stall <= 1'b0;
          1: chr_stall <= 1'($urandom_range(0, 1));
          2: chr_stall <= ($urandom_range(0, 3) != 0);
          default: chr_stall <= (cycle_count % 4 == 0);
        endcase
      end
    end
  end

  // Main stimulus: reset, directed requests, then random bursts.
  initial begin
    int burst;
    int sent;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Most lines target a boundary of the format rules: address
    // and parameter extremes including values above 999 (sent modulo 1000),
    // both edges of the three-digit write band and its three holes, the three
    // single parameters that also take three digits, the query range edges
    // (where data must be ignored), and data at and just past both clamps.
    offer(pack_req(0, 0, 0));
    offer(pack_req(999, 17, 999));
    offer(pack_req(1023, 100, 1000));
    idle_sender($urandom_range(1, 6));
    offer(pack_req(5, 16, 999999));
    offer(pack_req(123, 101, 1000000));
    offer(pack_req(1000, 23, 5));
    offer(pack_req(42, 50, 77));
    idle_sender($urandom_range(1, 6));
    offer(pack_req(7, 61, 12));
    offer(pack_req(8, 22, 1023));
    offer(pack_req(9, 24, 1048575));
    offer(pack_req(500, 300, 1048575));
    offer(pack_req(501, 399, 0));
    idle_sender($urandom_range(1, 6));
    offer(pack_req(502, 350, 123));
    offer(pack_req(503, 299, 123456));
    offer(pack_req(504, 400, 654321));
    offer(pack_req(505, 708, 998));
    offer(pack_req(506, 720, 2000));
    offer(pack_req(507, 797, 1048575));
    idle_sender($urandom_range(1, 6));
    offer(pack_req(508, 707, 999));
    offer(pack_req(509, 709, 999));
    offer(pack_req(510, 1000, 555));
    offer(pack_req(511, 1023, 1048575));
    offer(pack_req(1023, 1023, 1048575));

    // Random part: bursts of back-to-back requests separated by gaps, about a
    // third of the gaps being zero so long unbroken stretches also occur.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        offer(random_request());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_sender($urandom_range(1, 25));
      end
    end
    req_valid <= 1'b0;

    // Drain: every predicted character must come out, then a quiet tail lets
    // any stray extra character show up as a failure in the checker.
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a run that hangs is reported as a failure.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/aptb_pkg.sv
sv/aptb_front.sv
sv/aptb_queue.sv
sv/aptb_back.sv
sv/ascii_pump_telegram_builder_top.sv
sim/telegram_checker.sv
sim/tb_top.sv
